// File: hw/rtl/gff_pkg.sv
package gff_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SEED,
        ST_EVAL,
        ST_NBR,
        ST_POP,
        ST_LOAD
    } t_state;

    typedef enum logic [1:0] {
        DIR_XP,
        DIR_XM,
        DIR_YP,
        DIR_YM
    } t_dir;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_FILL  = 2'd2;

    localparam logic [0:0] CFG_TARGET  = 1'b0;
    localparam logic [0:0] CFG_REPLACE = 1'b1;

    localparam int         COLOR_W   = 2;
    localparam int         COUNT_W   = 9;
    localparam logic [8:0] COUNT_MAX = 9'h1ff;

endpackage

// File: hw/rtl/gff_ram.sv
module gff_ram #(
    parameter int DATA_W = 2,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/gff_nbr.sv
module gff_nbr #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16,
    parameter int XW          = 4,
    parameter int YW          = 4
) (
    input  logic [XW-1:0]      i_cur_x,
    input  logic [YW-1:0]      i_cur_y,
    input  gff_pkg::t_dir      i_dir,
    output logic [XW-1:0]      o_nb_x,
    output logic [YW-1:0]      o_nb_y,
    output logic               o_nb_ok
);

    logic [XW:0] x_inc;
    logic [YW:0] y_inc;

    assign x_inc = {1'b0, i_cur_x} + (XW+1)'(1);
    assign y_inc = {1'b0, i_cur_y} + (YW+1)'(1);

    always_comb begin
        o_nb_x  = i_cur_x;
        o_nb_y  = i_cur_y;
        o_nb_ok = 1'b0;
        unique case (i_dir)
            gff_pkg::DIR_XP: begin
                o_nb_x  = x_inc[XW-1:0];
                o_nb_ok = x_inc < (XW+1)'(GRID_WIDTH);
            end
            gff_pkg::DIR_XM: begin
                o_nb_x  = i_cur_x - XW'(1);
                o_nb_ok = i_cur_x != '0;
            end
            gff_pkg::DIR_YP: begin
                o_nb_y  = y_inc[YW-1:0];
                o_nb_ok = y_inc < (YW+1)'(GRID_HEIGHT);
            end
            gff_pkg::DIR_YM: begin
                o_nb_y  = i_cur_y - YW'(1);
                o_nb_ok = i_cur_y != '0;
            end
            default: begin
                o_nb_ok = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/grid_flood_fill_unit.sv
// grid_flood_fill_unit: a GRID_WIDTH x GRID_HEIGHT grid of 2-bit pixels with
// pixel write, pixel read and 4-connected flood fill.
// input stream: s_tuser carries the operation, s_tdata carries x, y and color;
// each accepted transaction gives exactly one output transaction carrying
// read_color and filled_count (zero where the operation has no such value).
// config port: i_cfg_we/i_cfg_addr/i_cfg_wdata write target_color (index 0)
// and replace_color (index 1); write only while the block is idle.
// sequence: write and unused codes answer straight from idle, read goes
// through a read state, and fill reads and compares the seed, then for each
// recolored pixel does a pop, a load, then a neighbor step for each of four
// neighbors and a compare for each neighbor inside the grid, all through the
// single port of the pixel ram. One item is in work at a time.
// reset: synchronous, active low; afterwards the pixel ram is cleared one
// entry per cycle, every address in turn, with s_tready low; config writes
// are taken meanwhile.
// stall: the result sits in an output register until m_tready; a new item is
// taken only once the pending result is gone or leaves in the same cycle.
module grid_flood_fill_unit #(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // x[3:0], y[7:4], color[9:8], zero pad
    input  logic [1:0]  i_s_tuser,   // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // read_color[1:0], filled_count[10:2], zero pad
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [1:0]  i_cfg_wdata
);

    localparam int XW  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int AW  = XW + YW;
    localparam int SPW = AW + 1;
    localparam int CW  = gff_pkg::COLOR_W;
    localparam int NW  = gff_pkg::COUNT_W;

    gff_pkg::t_state r_state, n_state;
    gff_pkg::t_dir   r_dir, n_dir;

    logic [XW-1:0]  r_cur_x, n_cur_x, r_cand_x, n_cand_x, nb_x, in_ax;
    logic [YW-1:0]  r_cur_y, n_cur_y, r_cand_y, n_cand_y, nb_y, in_ay;
    logic           nb_ok;
    logic           r_seed, n_seed;
    logic [SPW-1:0] r_sp, n_sp;
    logic [NW-1:0]  r_tally, n_tally;
    logic [AW-1:0]  r_clr_addr, n_clr_addr;
    logic [CW-1:0]  r_target, r_replace;
    logic           r_rd_ok, n_rd_ok;
    logic           r_out_valid, n_out_valid;
    logic [CW-1:0]  r_out_color, n_out_color;
    logic [NW-1:0]  r_out_count, n_out_count;

    logic [1:0]     in_func;
    logic [3:0]     in_x, in_y;
    logic [CW-1:0]  in_color;
    logic           in_inside, accept, fill_go, hit;

    logic           pix_we;
    logic [AW-1:0]  pix_addr;
    logic [CW-1:0]  pix_wdata, pix_rdata;
    logic           stk_we;
    logic [AW-1:0]  stk_addr, stk_wdata, stk_rdata;
    logic [SPW-1:0] sp_dec;

    assign in_func  = i_s_tuser;
    assign in_x     = i_s_tdata[3:0];
    assign in_y     = i_s_tdata[7:4];
    assign in_color = i_s_tdata[9:8];
    assign in_ax    = XW'(in_x);
    assign in_ay    = YW'(in_y);
    assign in_inside = ({28'd0, in_x} < 32'(GRID_WIDTH)) &&
                       ({28'd0, in_y} < 32'(GRID_HEIGHT));

    assign o_s_tready = (r_state == gff_pkg::ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign fill_go    = in_inside && (r_target != r_replace);
    assign hit        = pix_rdata == r_target;
    assign sp_dec     = r_sp - SPW'(1);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_count, r_out_color};

    gff_ram #(.DATA_W(CW), .ADDR_W(AW)) u_pix (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_addr  (pix_addr),
        .i_wdata (pix_wdata),
        .o_rdata (pix_rdata)
    );

    gff_ram #(.DATA_W(AW), .ADDR_W(AW)) u_stk (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_addr  (stk_addr),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata)
    );

    gff_nbr #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .XW          (XW),
        .YW          (YW)
    ) u_nbr (
        .i_cur_x (r_cur_x),
        .i_cur_y (r_cur_y),
        .i_dir   (r_dir),
        .o_nb_x  (nb_x),
        .o_nb_y  (nb_y),
        .o_nb_ok (nb_ok)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gff_pkg::ST_CLEAR: begin
                if (r_clr_addr == '1) n_state = gff_pkg::ST_IDLE;
            end
            gff_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        gff_pkg::FUNC_READ: n_state = gff_pkg::ST_READ;
                        gff_pkg::FUNC_FILL: begin
                            if (fill_go) n_state = gff_pkg::ST_SEED;
                        end
                        default: n_state = gff_pkg::ST_IDLE;
                    endcase
                end
            end
            gff_pkg::ST_READ: n_state = gff_pkg::ST_IDLE;
            gff_pkg::ST_SEED: n_state = gff_pkg::ST_EVAL;
            gff_pkg::ST_EVAL: begin
                if (r_seed || r_dir == gff_pkg::DIR_YM) n_state = gff_pkg::ST_POP;
                else n_state = gff_pkg::ST_NBR;
            end
            gff_pkg::ST_NBR: begin
                if (nb_ok) n_state = gff_pkg::ST_EVAL;
                else if (r_dir == gff_pkg::DIR_YM) n_state = gff_pkg::ST_POP;
            end
            gff_pkg::ST_POP: begin
                if (r_sp == '0) n_state = gff_pkg::ST_IDLE;
                else n_state = gff_pkg::ST_LOAD;
            end
            gff_pkg::ST_LOAD: n_state = gff_pkg::ST_NBR;
            default: n_state = gff_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_cand_x    = r_cand_x;
        n_cand_y    = r_cand_y;
        n_dir       = r_dir;
        n_seed      = r_seed;
        n_sp        = r_sp;
        n_tally     = r_tally;
        n_clr_addr  = r_clr_addr;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_color = r_out_color;
        n_out_count = r_out_count;
        pix_we      = 1'b0;
        pix_addr    = {r_cand_x, r_cand_y};
        pix_wdata   = r_replace;
        stk_we      = 1'b0;
        stk_addr    = r_sp[AW-1:0];
        stk_wdata   = {r_cand_x, r_cand_y};
        unique case (r_state)
            gff_pkg::ST_CLEAR: begin
                pix_we     = 1'b1;
                pix_addr   = r_clr_addr;
                pix_wdata  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            gff_pkg::ST_IDLE: begin
                pix_addr  = {in_ax, in_ay};
                pix_wdata = in_color;
                if (accept) begin
                    n_out_color = '0;
                    n_out_count = '0;
                    n_rd_ok     = in_inside;
                    n_cand_x    = in_ax;
                    n_cand_y    = in_ay;
                    n_tally     = '0;
                    n_seed      = 1'b1;
                    n_sp        = '0;
                    unique case (in_func)
                        gff_pkg::FUNC_WRITE: begin
                            pix_we      = in_inside;
                            n_out_valid = 1'b1;
                        end
                        gff_pkg::FUNC_READ: begin
                            n_out_valid = r_out_valid && !i_m_tready;
                        end
                        gff_pkg::FUNC_FILL: begin
                            n_out_valid = !fill_go;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            gff_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_out_color = r_rd_ok ? pix_rdata : '0;
            end
            gff_pkg::ST_SEED: begin
                pix_addr = {r_cand_x, r_cand_y};
            end
            gff_pkg::ST_EVAL: begin
                if (hit) begin
                    pix_we = 1'b1;
                    stk_we = 1'b1;
                    n_sp   = r_sp + SPW'(1);
                    if (r_tally != gff_pkg::COUNT_MAX) n_tally = r_tally + NW'(1);
                end
                if (!r_seed && r_dir != gff_pkg::DIR_YM) n_dir = gff_pkg::t_dir'(r_dir + 2'd1);
            end
            gff_pkg::ST_NBR: begin
                pix_addr = {nb_x, nb_y};
                if (nb_ok) begin
                    n_cand_x = nb_x;
                    n_cand_y = nb_y;
                end else if (r_dir != gff_pkg::DIR_YM) begin
                    n_dir = gff_pkg::t_dir'(r_dir + 2'd1);
                end
            end
            gff_pkg::ST_POP: begin
                stk_addr = sp_dec[AW-1:0];
                if (r_sp == '0) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_tally;
                end else begin
                    n_sp = sp_dec;
                end
            end
            gff_pkg::ST_LOAD: begin
                n_cur_x = stk_rdata[AW-1:YW];
                n_cur_y = stk_rdata[YW-1:0];
                n_dir   = gff_pkg::DIR_XP;
                n_seed  = 1'b0;
            end
            default: begin
                n_seed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gff_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_sp        <= '0;
            r_tally     <= '0;
            r_seed      <= 1'b0;
            r_dir       <= gff_pkg::DIR_XP;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_replace   <= CW'(1);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_sp        <= n_sp;
            r_tally     <= n_tally;
            r_seed      <= n_seed;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    gff_pkg::CFG_TARGET:  r_target  <= i_cfg_wdata;
                    gff_pkg::CFG_REPLACE: r_replace <= i_cfg_wdata;
                    default:              r_target  <= r_target;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_cand_x    <= n_cand_x;
        r_cand_y    <= n_cand_y;
        r_rd_ok     <= n_rd_ok;
        r_out_color <= n_out_color;
        r_out_count <= n_out_count;
    end

endmodule

// File: hw/rtl/gff_checker.sv
module gff_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output transaction changed");

    // no new transaction while a result is still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && o_m_tvalid) |-> i_m_tready)
        else $error("input taken while output blocked");

    // ram clear keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready during ram clear");

    // a result never carries both a color and a count
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != 2'd0) |-> (o_m_tdata[10:2] == 9'd0))
        else $error("result carries color and count");

endmodule

bind grid_flood_fill_unit gff_checker u_gff_checker (.*);

// File: bench/grid_flood_fill_unit_tb.sv
`timescale 1ns / 100ps

module grid_flood_fill_unit_tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int GRID_W      = 16;
    localparam int GRID_H      = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int END_CYCLES  = 20;

    typedef struct packed {
        logic [1:0] read_color;
        logic [8:0] filled_count;
    } t_fill_answer;

    class t_grid_fill_checker;
        logic [1:0]   pixels [GRID_W][GRID_H];
        logic [1:0]   target;
        logic [1:0]   replacement;
        logic [7:0]   pending_cells [$];
        int unsigned  recolored;
        t_fill_answer expected_answers [$];
        int           mismatches;

        function new();
            foreach (pixels[i, j]) pixels[i][j] = '0;
            target      = 2'd0;
            replacement = 2'd1;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [0:0] index, logic [1:0] value);
            if (index == gff_pkg::CFG_TARGET) begin
                target = value;
            end else begin
                replacement = value;
            end
        endfunction

        // recolor one pixel of the target color and queue it for its neighbors
        function void visit(int x, int y);
            if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return;
            if (pixels[x][y] != target) return;
            pixels[x][y] = replacement;
            recolored++;
            pending_cells.push_back(8'(x * GRID_H + y));
        endfunction

        function logic [8:0] flood(int x, int y);
            logic [7:0] spot;
            recolored = 0;
            pending_cells.delete();
            if (target == replacement) return '0;
            visit(x, y);
            while (pending_cells.size() > 0) begin
                spot = pending_cells.pop_back();
                visit(int'(spot[7:4]) + 1, int'(spot[3:0]));
                visit(int'(spot[7:4]) - 1, int'(spot[3:0]));
                visit(int'(spot[7:4]), int'(spot[3:0]) + 1);
                visit(int'(spot[7:4]), int'(spot[3:0]) - 1);
            end
            return (recolored > gff_pkg::COUNT_MAX) ? gff_pkg::COUNT_MAX : recolored[8:0];
        endfunction

        function void take_op(logic [1:0] func, logic [3:0] x, logic [3:0] y,
                              logic [1:0] color);
            t_fill_answer answer;
            answer = '0;
            case (func)
                gff_pkg::FUNC_WRITE: pixels[x][y] = color;
                gff_pkg::FUNC_READ:  answer.read_color = pixels[x][y];
                gff_pkg::FUNC_FILL:  answer.filled_count = flood(int'(x), int'(y));
                default: ;
            endcase
            expected_answers.push_back(answer);
        endfunction

        function void report(string field, logic [8:0] want, logic [8:0] got);
            if (mismatches < 10) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
            mismatches++;
        endfunction

        function void check_answer(logic [15:0] data);
            t_fill_answer want;
            if (expected_answers.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected output transaction, tdata %h", $time, data);
                end
                mismatches++;
                return;
            end
            want = expected_answers.pop_front();
            if (data[1:0] !== want.read_color) begin
                report("read_color", 9'(want.read_color), 9'(data[1:0]));
            end
            if (data[10:2] !== want.filled_count) begin
                report("filled_count", want.filled_count, data[10:2]);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // x[3:0], y[7:4], color[9:8], zero pad
    logic [1:0]  i_s_tuser;   // func[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // read_color[1:0], filled_count[10:2], zero pad
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [1:0]  i_cfg_wdata;

    t_grid_fill_checker sb = new();
    bit tx_steady;
    bit rx_steady;
    bit hold_output;
    int idle_cycles;

    grid_flood_fill_unit i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(logic [1:0] func, logic [3:0] x, logic [3:0] y, logic [1:0] color);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, color, y, x};
        i_s_tuser  <= func;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.take_op(func, x, y, color);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_answers.size() != 0);
    endtask

    task automatic set_config(logic [1:0] target, logic [1:0] replacement);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= gff_pkg::CFG_TARGET;
        i_cfg_wdata <= target;
        @(posedge i_clk);
        sb.set_reg(gff_pkg::CFG_TARGET, target);
        i_cfg_addr  <= gff_pkg::CFG_REPLACE;
        i_cfg_wdata <= replacement;
        @(posedge i_clk);
        sb.set_reg(gff_pkg::CFG_REPLACE, replacement);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(logic [1:0] target, logic [1:0] replacement, int n_items,
                                bit with_hold, bit with_pause);
        int         sent;
        int         pick;
        int         len;
        int         x0;
        int         y0;
        bit         along_x;
        bit         held;
        bit         paused;
        logic [1:0] color;
        set_config(target, replacement);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < n_items) begin
            if (with_hold && !held && sent >= 10) begin
                hold_output = 1'b1;
                held = 1'b1;
            end
            if (with_pause && !paused && sent >= n_items / 2) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            x0   = $urandom_range(0, GRID_W - 1);
            y0   = $urandom_range(0, GRID_H - 1);
            if (pick < 20) begin
                // straight stroke of one color, often the fill target
                color   = $urandom_range(0, 1) ? sb.target : 2'($urandom_range(0, 3));
                along_x = $urandom_range(0, 1);
                len     = $urandom_range(2, 16);
                for (int k = 0; k < len && sent < n_items; k++) begin
                    if (along_x && x0 + k < GRID_W) begin
                        send_op(gff_pkg::FUNC_WRITE, 4'(x0 + k), 4'(y0), color);
                        sent++;
                    end else if (!along_x && y0 + k < GRID_H) begin
                        send_op(gff_pkg::FUNC_WRITE, 4'(x0), 4'(y0 + k), color);
                        sent++;
                    end
                end
            end else if (pick < 32) begin
                if ($urandom_range(0, 3) == 0) begin
                    x0 = $urandom_range(0, 1) * (GRID_W - 1);
                    y0 = $urandom_range(0, 1) * (GRID_H - 1);
                end
                send_op(gff_pkg::FUNC_FILL, 4'(x0), 4'(y0), 2'($urandom_range(0, 3)));
                sent++;
            end else if (pick < 36) begin
                send_op(FUNC_UNUSED, 4'(x0), 4'(y0), 2'($urandom_range(0, 3)));
                sent++;
            end else if (pick < 56) begin
                send_op(gff_pkg::FUNC_READ, 4'(x0), 4'(y0), 2'($urandom_range(0, 3)));
                sent++;
            end else begin
                send_op(gff_pkg::FUNC_WRITE, 4'(x0), 4'(y0), 2'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    initial begin
        int stall;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_output) begin
                stall = HOLD_CYCLES;
                hold_output = 1'b0;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            sb.check_answer(o_m_tdata);
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= gff_pkg::FUNC_WRITE;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= gff_pkg::CFG_TARGET;
        i_cfg_wdata <= '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        hold_output = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cleared grid, whole-grid fill, corners and edges
        send_op(gff_pkg::FUNC_READ, 4'd0, 4'd0, 2'd0);
        send_op(gff_pkg::FUNC_FILL, 4'd15, 4'd15, 2'd0);
        send_op(gff_pkg::FUNC_READ, 4'd9, 4'd4, 2'd0);
        send_op(gff_pkg::FUNC_WRITE, 4'd15, 4'd15, 2'd3);
        send_op(gff_pkg::FUNC_WRITE, 4'd0, 4'd15, 2'd2);
        send_op(gff_pkg::FUNC_WRITE, 4'd15, 4'd0, 2'd0);
        send_op(gff_pkg::FUNC_WRITE, 4'd0, 4'd0, 2'd3);
        send_op(gff_pkg::FUNC_READ, 4'd15, 4'd15, 2'd1);
        send_op(gff_pkg::FUNC_READ, 4'd0, 4'd15, 2'd2);
        send_op(gff_pkg::FUNC_READ, 4'd15, 4'd0, 2'd3);
        send_op(FUNC_UNUSED, 4'd15, 4'd15, 2'd3);
        send_op(gff_pkg::FUNC_FILL, 4'd0, 4'd0, 2'd0);
        send_op(gff_pkg::FUNC_FILL, 4'd15, 4'd0, 2'd0);
        set_config(2'd1, 2'd1);
        send_op(gff_pkg::FUNC_FILL, 4'd4, 4'd4, 2'd0);
        set_config(2'd1, 2'd2);
        send_op(gff_pkg::FUNC_FILL, 4'd8, 4'd8, 2'd0);
        set_config(2'd3, 2'd0);
        send_op(gff_pkg::FUNC_FILL, 4'd0, 4'd0, 2'd0);
        send_op(gff_pkg::FUNC_FILL, 4'd15, 4'd15, 2'd0);
        send_op(FUNC_UNUSED, 4'd0, 4'd0, 2'd0);

        random_phase(2'd0, 2'd1, 70, 1'b1, 1'b0);
        random_phase(2'd1, 2'd2, 70, 1'b0, 1'b0);
        random_phase(2'd3, 2'd0, 70, 1'b0, 1'b1);
        random_phase(2'd2, 2'd2, 70, 1'b0, 1'b0);
        random_phase(2'd0, 2'd3, 70, 1'b0, 1'b0);
        random_phase(2'd3, 2'd1, 70, 1'b1, 1'b0);
        random_phase(2'd1, 2'd0, 70, 1'b0, 1'b1);
        random_phase(2'd2, 2'd3, 70, 1'b0, 1'b0);

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: grid_flood_fill_unit.f
hw/rtl/gff_pkg.sv
hw/rtl/gff_ram.sv
hw/rtl/gff_nbr.sv
hw/rtl/grid_flood_fill_unit.sv
hw/rtl/gff_checker.sv
bench/grid_flood_fill_unit_tb.sv
